FILE: rtl/fes_pkg.sv
`default_nettype none

package fes_pkg;

  // Semi-axis width used by the span arithmetic.
  localparam int AXIS_BITS  = 8;
  localparam int AA_W       = 2 * AXIS_BITS;
  localparam int NUM_W      = 4 * AXIS_BITS;
  localparam int REM_W      = AXIS_BITS + 1;
  localparam int DIV_CELLS  = AA_W;
  localparam int SQRT_CELLS = AXIS_BITS;

  localparam int ROW_W      = 9;
  localparam int POS_W      = 9;
  localparam int SEMI_W     = 8;
  localparam int COORD_W    = 11;
  localparam int COLOR_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [POS_W-1:0] CENTER_RESET = POS_W'(120);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_COL      = 3'd0,
    REG_CENTER_ROW      = 3'd1,
    REG_SEMI_VERTICAL   = 3'd2,
    REG_SEMI_HORIZONTAL = 3'd3,
    REG_FILL_COLOR      = 3'd4
  } cfg_reg_e;

  // Shape values seen by the arithmetic.
  typedef struct packed {
    logic [AXIS_BITS-1:0] a;
    logic [AXIS_BITS-1:0] b;
    logic [AA_W-1:0]      aa;
  } shape_t;

  // Per-request sideband that rides along the whole chain.
  typedef struct packed {
    logic signed [ROW_W-1:0] y;
    logic                    empty;
    logic                    kill;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [AA_W-1:0] p;
    logic [AA_W-1:0] low;
  } div_t;

  typedef struct packed {
    side_t                side;
    logic [REM_W-1:0]     rem;
    logic [AXIS_BITS-1:0] root;
    logic [AA_W-1:0]      val;
  } sqrt_t;

endpackage

`default_nettype wire

FILE: rtl/fes_front.sv
`default_nettype none

module fes_front import fes_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire shape_t             shape_i,
  input  wire                     valid_i,
  output logic                    ready_o,
  input  wire  signed [ROW_W-1:0] y_i,
  output logic                    valid_o,
  input  wire                     ready_i,
  output div_t                    data_o
);

  logic            va_q, vb_q;
  side_t           side_a_q, side_b_q;
  logic [AA_W-1:0] diff_q, bb_q;
  logic [NUM_W-1:0] num_q;

  logic            ready_a, ready_b;
  logic [ROW_W-1:0] y_u, ay;
  logic [AXIS_BITS-1:0] ay_a;
  logic [AA_W-1:0] yy;
  side_t           side_d;

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  always_comb begin
    y_u   = y_i;
    ay    = y_u[ROW_W-1] ? (~y_u + ROW_W'(1)) : y_u;
    ay_a  = AXIS_BITS'(ay);
    yy    = ay_a * ay_a;
    side_d.y     = y_i;
    side_d.empty = 32'(ay) > 32'(shape_i.a);
    side_d.kill  = side_d.empty || (shape_i.a == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      side_a_q <= side_d;
      diff_q   <= shape_i.aa - yy;
      bb_q     <= shape_i.b * shape_i.b;
    end
    if (ready_b && va_q) begin
      side_b_q <= side_a_q;
      num_q    <= bb_q * diff_q;
    end
  end

  assign valid_o     = vb_q;
  assign data_o.side = side_b_q;
  assign data_o.p    = num_q[NUM_W-1:AA_W];
  assign data_o.low  = num_q[AA_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/fes_div_cell.sv
`default_nettype none

module fes_div_cell import fes_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire [AA_W-1:0]  divisor_i,
  input  wire             valid_i,
  output logic            ready_o,
  input  wire div_t       data_i,
  output logic            valid_o,
  input  wire             ready_i,
  output div_t            data_o
);

  logic            valid_q;
  div_t            data_q, data_d;
  logic [AA_W:0]   t, dv;
  logic            ge;

  assign ready_o = !valid_q || ready_i;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    t  = {data_i.p, data_i.low[AA_W-1]};
    dv = {1'b0, divisor_i};
    ge = t >= dv;
    data_d.side = data_i.side;
    data_d.p    = ge ? AA_W'(t - dv) : t[AA_W-1:0];
    data_d.low  = {data_i.low[AA_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/fes_sqrt_cell.sv
`default_nettype none

module fes_sqrt_cell import fes_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       ready_o,
  input  wire sqrt_t data_i,
  output logic       valid_o,
  input  wire        ready_i,
  output sqrt_t      data_o
);

  logic             valid_q;
  sqrt_t            data_q, data_d;
  logic [REM_W+1:0] t, trial;
  logic             ge;

  assign ready_o = !valid_q || ready_i;

  // One root digit: bring down two radicand bits, try root*4+1.
  always_comb begin
    t     = {data_i.rem, data_i.val[AA_W-1:AA_W-2]};
    trial = (REM_W+2)'({data_i.root, 2'b01});
    ge    = t >= trial;
    data_d.side = data_i.side;
    data_d.rem  = ge ? REM_W'(t - trial) : REM_W'(t);
    data_d.root = {data_i.root[AXIS_BITS-2:0], ge};
    data_d.val  = {data_i.val[AA_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/filled_ellipse_span_unit.sv
// Filled ellipse span unit: one horizontal span per row offset request.
// Pipeline: 27 register stages (2 front stages, 16 divider cells, 8 square root
//   cells, 1 output register).
// Throughput: one request per cycle unless span_ready_i stalls the output;
//   the cell chain, one bit a cell, sets it.
// Reset: asynchronous active low; clears all valid bits, centers go to 120,
//   semi-axes and color to 0.
`default_nettype none

module filled_ellipse_span_unit import fes_pkg::*; (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration write port
  input  wire                        cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]      cfg_data_i,
  // row offset requests
  input  wire                        row_offset_valid_i,
  output logic                       row_offset_ready_o,
  input  wire  signed [ROW_W-1:0]    row_offset_i,
  // span results
  output logic                       span_valid_o,
  input  wire                        span_ready_i,
  output logic signed [COORD_W-1:0]  span_row_o,
  output logic signed [COORD_W-1:0]  span_left_o,
  output logic signed [COORD_W-1:0]  span_right_o,
  output logic        [COLOR_W-1:0]  span_color_o,
  output logic                       span_empty_o
);

  // ---------------------------------------------------------------------
  // Configuration registers. The user must write them only while no request is in
  // flight; the block itself does not enforce this. Every stage reads them directly.
  // ---------------------------------------------------------------------
  logic [POS_W-1:0]     center_col_q, center_row_q;
  logic [SEMI_W-1:0]    semi_vert_q, semi_horz_q;
  logic [COLOR_W-1:0]   fill_color_q;
  logic [AA_W-1:0]      aa_q;
  logic [AXIS_BITS-1:0] a_wr;
  shape_t               shape;

  // Square the new vertical semi-axis as it is written, so a*a is ready
  // together with a for a request accepted right after the write.
  assign a_wr = AXIS_BITS'(cfg_data_i[SEMI_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q <= CENTER_RESET;
      center_row_q <= CENTER_RESET;
      semi_vert_q  <= '0;
      semi_horz_q  <= '0;
      fill_color_q <= '0;
      aa_q         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_COL:      center_col_q <= cfg_data_i[POS_W-1:0];
        REG_CENTER_ROW:      center_row_q <= cfg_data_i[POS_W-1:0];
        REG_SEMI_VERTICAL: begin
          semi_vert_q <= cfg_data_i[SEMI_W-1:0];
          aa_q        <= a_wr * a_wr;
        end
        REG_SEMI_HORIZONTAL: semi_horz_q  <= cfg_data_i[SEMI_W-1:0];
        REG_FILL_COLOR:      fill_color_q <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign shape.a  = AXIS_BITS'(semi_vert_q);
  assign shape.b  = AXIS_BITS'(semi_horz_q);
  assign shape.aa = aa_q;

  // ---------------------------------------------------------------------
  // Front: |y|, inside test, b*b*(a*a - y*y).
  // ---------------------------------------------------------------------
  logic [DIV_CELLS:0]  div_valid, div_ready;
  div_t                div_bus [DIV_CELLS+1];

  fes_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shape_i (shape),
    .valid_i (row_offset_valid_i),
    .ready_o (row_offset_ready_o),
    .y_i     (row_offset_i),
    .valid_o (div_valid[0]),
    .ready_i (div_ready[0]),
    .data_o  (div_bus[0])
  );

  // ---------------------------------------------------------------------
  // Divider chain: one quotient bit per cell, divisor a*a.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    fes_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (aa_q),
      .valid_i   (div_valid[i]),
      .ready_o   (div_ready[i]),
      .data_i    (div_bus[i]),
      .valid_o   (div_valid[i+1]),
      .ready_i   (div_ready[i+1]),
      .data_o    (div_bus[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Square root chain: the quotient enters as radicand, one root bit a cell.
  // ---------------------------------------------------------------------
  logic [SQRT_CELLS:0] sq_valid, sq_ready;
  sqrt_t               sq_bus [SQRT_CELLS+1];

  assign sq_valid[0]          = div_valid[DIV_CELLS];
  assign div_ready[DIV_CELLS] = sq_ready[0];
  assign sq_bus[0].side       = div_bus[DIV_CELLS].side;
  assign sq_bus[0].rem        = '0;
  assign sq_bus[0].root       = '0;
  assign sq_bus[0].val        = div_bus[DIV_CELLS].low;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    fes_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[j]),
      .ready_o (sq_ready[j]),
      .data_i  (sq_bus[j]),
      .valid_o (sq_valid[j+1]),
      .ready_i (sq_ready[j+1]),
      .data_o  (sq_bus[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: place the span around the center. Rows outside the
  // ellipse, and every row when a is zero, get half width zero.
  // ---------------------------------------------------------------------
  logic                      out_valid_q;
  logic signed [COORD_W-1:0] row_q, left_q, right_q;
  logic [COLOR_W-1:0]        color_q;
  logic                      empty_q;
  logic                      out_load;
  sqrt_t                     last;
  logic [AXIS_BITS-1:0]      half_w;
  logic signed [COORD_W-1:0] y_ext, row_d, left_d, right_d;

  assign last                 = sq_bus[SQRT_CELLS];
  assign sq_ready[SQRT_CELLS] = !out_valid_q || span_ready_i;
  assign out_load             = sq_ready[SQRT_CELLS] && sq_valid[SQRT_CELLS];

  always_comb begin
    half_w  = last.side.kill ? '0 : last.root;
    y_ext   = COORD_W'(last.side.y);
    row_d   = COORD_W'($signed({2'b00, center_row_q}) + y_ext);
    left_d  = COORD_W'(32'(center_col_q) - 32'(half_w));
    right_d = COORD_W'(32'(center_col_q) + 32'(half_w));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sq_ready[SQRT_CELLS]) begin
      out_valid_q <= sq_valid[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      row_q   <= row_d;
      left_q  <= left_d;
      right_q <= right_d;
      color_q <= fill_color_q;
      empty_q <= last.side.empty;
    end
  end

  assign span_valid_o = out_valid_q;
  assign span_row_o   = row_q;
  assign span_left_o  = left_q;
  assign span_right_o = right_q;
  assign span_color_o = color_q;
  assign span_empty_o = empty_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_empty_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o && span_empty_o |-> span_left_o == span_right_o)
    else $error("empty span with nonzero width");

  a_stall_full_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !row_offset_ready_o |-> span_valid_o && !span_ready_i)
    else $error("request refused while the chain has a free slot");

  a_out_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(span_valid_o) |-> $past(sq_valid[SQRT_CELLS]))
    else $error("span appeared without a finished request");

endmodule

`default_nettype wire
